>>> sv/leveled_task_slot_table_macros.svh
// Assertion macros for the leveled task slot table.
// Taken in by the top level only; needs no package.
`ifndef LEVELED_TASK_SLOT_TABLE_MACROS_SVH
`define LEVELED_TASK_SLOT_TABLE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LTST_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LTST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/ltst_pkg.sv
// Shared types and codes for the leveled task slot table.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package ltst_pkg;

   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_DEL = 1'b1;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // One stored slot entry.
   typedef struct packed {
      logic [15:0] task_id;
      logic [15:0] period;
      logic [15:0] start_tick;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load;       // capture request, set up walk
      logic       step;       // advance walk position
      logic       add_take;   // claim current slot
      logic       del_issue;  // read id at current slot
      logic       del_free;   // free the slot under compare
      logic       rsp_fire;   // present a result word
      logic [1:0] rsp_status;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic slot_free;  // current slot unoccupied
      logic at_last;    // current slot is last of the level
      logic cmp_hit;    // compare stage holds an occupied matching id
   } stat_type;

endpackage

>>> sv/ltst_ctrl.sv
// Sequencer for the leveled task slot table.
// Depends on ltst_pkg; drives the datapath through cmd_type.
`timescale 1ns / 1ps

module ltst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_action,
   input  ltst_pkg::stat_type stat,
   output ltst_pkg::cmd_type  cmd,
   output logic               busy
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ADD   = 2'd1;
   localparam logic [1:0] S_DEL   = 2'd2;
   localparam logic [1:0] S_DRAIN = 2'd3;

   logic [1:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = ltst_pkg::STATUS_DONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_action == ltst_pkg::ACTION_ADD) ? S_ADD : S_DEL;
            end
         end
         S_ADD: begin
            if (stat.slot_free) begin
               cmd.add_take = 1'b1;
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end else if (stat.at_last) begin
               cmd.rsp_fire   = 1'b1;
               cmd.rsp_status = ltst_pkg::STATUS_FULL;
               state_in       = S_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         S_DEL: begin
            if (stat.cmp_hit) begin
               cmd.del_free = 1'b1;
               cmd.rsp_fire = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.del_issue = 1'b1;
               if (stat.at_last) begin
                  state_in = S_DRAIN;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         S_DRAIN: begin
            // last read comes back here
            cmd.rsp_fire = 1'b1;
            if (stat.cmp_hit) begin
               cmd.del_free = 1'b1;
            end else begin
               cmd.rsp_status = ltst_pkg::STATUS_NOT_FOUND;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> sv/ltst_datapath.sv
// Datapath: occupancy bitmaps, slot entry memory, walk counters, result word.
// Depends on ltst_pkg; commanded by ltst_ctrl.
`timescale 1ns / 1ps

module ltst_datapath #(
   parameter int LEVEL0_GROUPS   = 2,
   parameter int LEVEL1_GROUPS   = 2,
   parameter int LEVEL2_GROUPS   = 2,
   parameter int LEVEL3_GROUPS   = 2,
   parameter int SLOTS_PER_GROUP = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  ltst_pkg::cmd_type  cmd,
   output ltst_pkg::stat_type stat,
   input  logic [1:0]         req_level,
   input  logic [15:0]        req_task_id,
   input  logic [15:0]        req_period,
   input  logic [15:0]        req_start_tick,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [2:0]         rsp_group_index,
   output logic [4:0]         rsp_slot_index
);

   localparam int TOTAL_GROUPS = LEVEL0_GROUPS + LEVEL1_GROUPS + LEVEL2_GROUPS
                                 + LEVEL3_GROUPS;
   localparam int TOTAL_SLOTS  = TOTAL_GROUPS * SLOTS_PER_GROUP;
   localparam int GW = $clog2(TOTAL_GROUPS);
   localparam int SW = $clog2(SLOTS_PER_GROUP);
   localparam int AW = $clog2(TOTAL_SLOTS);

   localparam int L3_FIRST = 0;
   localparam int L2_FIRST = LEVEL3_GROUPS;
   localparam int L1_FIRST = LEVEL3_GROUPS + LEVEL2_GROUPS;
   localparam int L0_FIRST = LEVEL3_GROUPS + LEVEL2_GROUPS + LEVEL1_GROUPS;

   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_GROUP - 1);

   logic [SLOTS_PER_GROUP-1:0] occ_ff [TOTAL_GROUPS];
   ltst_pkg::entry_type        mem    [TOTAL_SLOTS];

   logic [15:0]         id_ff, period_ff, start_ff;
   logic [GW-1:0]       grp_ff, last_grp_ff, first_grp, last_grp;
   logic [SW-1:0]       slot_ff;
   logic [AW-1:0]       cur_addr;
   logic                cur_occ;
   ltst_pkg::entry_type rd_ff;
   logic                cmp_vld_ff;
   logic [GW-1:0]       cmp_grp_ff;
   logic [SW-1:0]       cmp_slot_ff;
   logic                rsp_strobe_ff;
   logic [1:0]          rsp_status_ff;
   logic [2:0]          rsp_group_ff;
   logic [4:0]          rsp_slot_ff;

   // group range of the requested level
   always_comb begin
      case (req_level)
         2'd3:    begin
            first_grp = GW'(L3_FIRST);
            last_grp  = GW'(L3_FIRST + LEVEL3_GROUPS - 1);
         end
         2'd2:    begin
            first_grp = GW'(L2_FIRST);
            last_grp  = GW'(L2_FIRST + LEVEL2_GROUPS - 1);
         end
         2'd1:    begin
            first_grp = GW'(L1_FIRST);
            last_grp  = GW'(L1_FIRST + LEVEL1_GROUPS - 1);
         end
         default: begin
            first_grp = GW'(L0_FIRST);
            last_grp  = GW'(L0_FIRST + LEVEL0_GROUPS - 1);
         end
      endcase
   end

   assign cur_addr = AW'(grp_ff) * AW'(SLOTS_PER_GROUP) + AW'(slot_ff);
   assign cur_occ  = occ_ff[grp_ff][slot_ff];

   assign stat.slot_free = !cur_occ;
   assign stat.at_last   = (slot_ff == LAST_SLOT) && (grp_ff == last_grp_ff);
   assign stat.cmp_hit   = cmp_vld_ff && (rd_ff.task_id == id_ff);

   // request capture and walk position
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff       <= req_task_id;
         period_ff   <= req_period;
         start_ff    <= req_start_tick;
         grp_ff      <= first_grp;
         last_grp_ff <= last_grp;
         slot_ff     <= '0;
      end else if (cmd.step) begin
         if (slot_ff == LAST_SLOT) begin
            slot_ff <= '0;
            grp_ff  <= grp_ff + GW'(1);
         end else begin
            slot_ff <= slot_ff + SW'(1);
         end
      end
   end

   // occupancy bitmaps
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < TOTAL_GROUPS; g++) begin
            occ_ff[g] <= '0;
         end
      end else if (cmd.add_take) begin
         occ_ff[grp_ff][slot_ff] <= 1'b1;
      end else if (cmd.del_free) begin
         occ_ff[cmp_grp_ff][cmp_slot_ff] <= 1'b0;
      end
   end

   // slot entry memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.add_take) begin
         mem[cur_addr] <= '{task_id: id_ff, period: period_ff, start_tick: start_ff};
      end
      if (cmd.del_issue) begin
         rd_ff <= mem[cur_addr];
      end
   end

   // compare stage tag
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.del_issue && cur_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.del_issue) begin
         cmp_grp_ff  <= grp_ff;
         cmp_slot_ff <= slot_ff;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_fire) begin
         rsp_status_ff <= cmd.rsp_status;
         if (cmd.add_take) begin
            rsp_group_ff <= 3'(grp_ff);
            rsp_slot_ff  <= 5'(slot_ff);
         end else if (cmd.del_free) begin
            rsp_group_ff <= 3'(cmp_grp_ff);
            rsp_slot_ff  <= 5'(cmp_slot_ff);
         end else begin
            rsp_group_ff <= '0;
            rsp_slot_ff  <= '0;
         end
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_group_index = rsp_group_ff;
   assign rsp_slot_index  = rsp_slot_ff;

endmodule

>>> sv/leveled_task_slot_table.sv
// Top level of the leveled task slot table: controller plus datapath.
// Depends on ltst_pkg, ltst_ctrl, ltst_datapath and the assertion macro header.
`timescale 1ns / 1ps

// Leveled task slot table. Groups of SLOTS_PER_GROUP slots are laid out level 3
// first, then levels 2, 1 and 0; each group keeps an occupancy bitmap. A request
// word is taken when start is high and busy is low. Add walks the level's slots
// one per clock (group order, lowest slot first) and claims the first free one,
// storing id, period and start tick; delete walks the same order, reading one
// stored id per clock from the slot memory and freeing the first occupied slot
// whose id matches. Exactly one result word follows each request: rsp_strobe is
// high for one clock with status, group and slot; it cannot be held off, so the
// receiver must take it in that clock. An add answers once its walk reaches a
// free slot, or reports full when the level's last slot is taken too; a delete
// answers once a read id compares as a match, or reports not found after the
// read of the last slot has come back. A level holds its group count times
// SLOTS_PER_GROUP slots, 64 per level at the defaults. busy drops in the
// clock the result shows, so the next word may be accepted then. Bitmaps clear
// at reset; the slot memory needs no clearing since an id read from an
// unoccupied slot is never compared.
module leveled_task_slot_table #(
   parameter int LEVEL0_GROUPS   = 2,
   parameter int LEVEL1_GROUPS   = 2,
   parameter int LEVEL2_GROUPS   = 2,
   parameter int LEVEL3_GROUPS   = 2,
   parameter int SLOTS_PER_GROUP = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [1:0]  req_level,
   input  logic [15:0] req_task_id,
   input  logic [15:0] req_period,
   input  logic [15:0] req_start_tick,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_group_index,
   output logic [4:0]  rsp_slot_index
);

`include "leveled_task_slot_table_macros.svh"

   ltst_pkg::cmd_type  cmd;
   ltst_pkg::stat_type stat;

   // sequencer: idle, add walk, delete walk, delete drain
   ltst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   // bitmaps, entry memory, walk counters and result word
   ltst_datapath #(
      .LEVEL0_GROUPS   (LEVEL0_GROUPS),
      .LEVEL1_GROUPS   (LEVEL1_GROUPS),
      .LEVEL2_GROUPS   (LEVEL2_GROUPS),
      .LEVEL3_GROUPS   (LEVEL3_GROUPS),
      .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_level       (req_level),
      .req_task_id     (req_task_id),
      .req_period      (req_period),
      .req_start_tick  (req_start_tick),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_group_index (rsp_group_index),
      .rsp_slot_index  (rsp_slot_index)
   );

   // an accepted word always makes the block busy in the cycle after acceptance
   `LTST_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")

   // strobes never run back to back
   `LTST_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe, "double result")

   // a result word ends a busy period
   `LTST_ASSERT_SAME(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy), "stray result")

   // failed requests report position zero
   `LTST_ASSERT_SAME(a_fail_zero, clock, reset,
      rsp_strobe && (rsp_status != ltst_pkg::STATUS_DONE),
      (rsp_group_index == 3'd0) && (rsp_slot_index == 5'd0), "failure with position")

endmodule

>>> verif/tb_leveled_task_slot_table.sv
// Self-checking testbench for leveled_task_slot_table: add/delete words against a
// local slot-table predictor, directed rows first, then random mixes with idle gaps.
// Depends on ltst_pkg and the leveled_task_slot_table RTL.
`timescale 1ns / 1ps

module tb_leveled_task_slot_table;

   localparam logic       ACTION_ADD       = ltst_pkg::ACTION_ADD;
   localparam logic       ACTION_DEL       = ltst_pkg::ACTION_DEL;
   localparam logic [1:0] STATUS_DONE      = ltst_pkg::STATUS_DONE;
   localparam logic [1:0] STATUS_FULL      = ltst_pkg::STATUS_FULL;
   localparam logic [1:0] STATUS_NOT_FOUND = ltst_pkg::STATUS_NOT_FOUND;

   // Geometry matches the block's defaults.
   localparam int L0_GROUPS  = 2;
   localparam int L1_GROUPS  = 2;
   localparam int L2_GROUPS  = 2;
   localparam int L3_GROUPS  = 2;
   localparam int SLOTS      = 32;
   localparam int ALL_GROUPS = L0_GROUPS + L1_GROUPS + L2_GROUPS + L3_GROUPS;
   localparam int TAIL_WAIT  = 80;    // margin past the longest walk at these sizes
   localparam int RAND_WORDS = 116;   // per random phase, four phases

   // One result word.
   typedef struct packed {
      logic [1:0] status;
      logic [2:0] grp;
      logic [4:0] slot;
   } slot_answer_type;

   // One directed row; reps > 1 repeats it with the id counting up.
   typedef struct {
      logic            act;
      logic [1:0]      lvl;
      logic [15:0]     id;
      logic [15:0]     per;
      logic [15:0]     st;
      int              reps;
      bit              known;
      slot_answer_type ans;
   } stim_row_type;

   localparam int N_ROWS = 21;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = ACTION_ADD;
   logic [1:0]  req_level = 2'd0;
   logic [15:0] req_task_id = 16'd0;
   logic [15:0] req_period = 16'd0;
   logic [15:0] req_start_tick = 16'd0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_group_index;
   logic [4:0]  rsp_slot_index;

   // Typed-in answer travelling with the word on the bus (NBA, like the ports).
   bit              typed_known = 1'b0;
   slot_answer_type typed_answer = '0;

   // Predictor state.
   logic [31:0] occ_bits    [ALL_GROUPS];
   logic [15:0] held_id     [ALL_GROUPS*SLOTS];
   logic [15:0] held_period [ALL_GROUPS*SLOTS];
   logic [15:0] held_start  [ALL_GROUPS*SLOTS];

   slot_answer_type answers_due[$];
   int              fault_count = 0;

   leveled_task_slot_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_level       (req_level),
      .req_task_id     (req_task_id),
      .req_period      (req_period),
      .req_start_tick  (req_start_tick),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_group_index (rsp_group_index),
      .rsp_slot_index  (rsp_slot_index)
   );

   always #6 clock = ~clock;

   // Run guard: far beyond the slowest legal run (548 words, each at the longest walk).
   initial begin
      #5000000;
      $display("** leveled_task_slot_table: FAILED **");
      $finish;
   end

   // Level 3 groups sit first, then 2, 1, 0.
   function automatic void level_groups(input logic [1:0] lvl, output int first,
                                        output int last);
      case (lvl)
         2'd3: begin first = 0; last = L3_GROUPS; end
         2'd2: begin first = L3_GROUPS; last = first + L2_GROUPS; end
         2'd1: begin first = L3_GROUPS + L2_GROUPS; last = first + L1_GROUPS; end
         default: begin
            first = L3_GROUPS + L2_GROUPS + L1_GROUPS;
            last  = first + L0_GROUPS;
         end
      endcase
   endfunction

   // Applies one word to the local table and returns the answer it should draw.
   function automatic slot_answer_type book_slot_op(input logic act, input logic [1:0] lvl,
                                                    input logic [15:0] id,
                                                    input logic [15:0] per,
                                                    input logic [15:0] st);
      int              first, last;
      slot_answer_type ans;
      ans = '{(act == ACTION_ADD) ? STATUS_FULL : STATUS_NOT_FOUND, 3'd0, 5'd0};
      level_groups(lvl, first, last);
      for (int g = first; g < last; g++) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (act == ACTION_ADD && !occ_bits[g][s]) begin
               occ_bits[g][s]            = 1'b1;
               held_id[g*SLOTS + s]      = id;
               held_period[g*SLOTS + s]  = per;
               held_start[g*SLOTS + s]   = st;
               return '{STATUS_DONE, g[2:0], s[4:0]};
            end
            if (act == ACTION_DEL && occ_bits[g][s] && held_id[g*SLOTS + s] == id) begin
               occ_bits[g][s] = 1'b0;
               return '{STATUS_DONE, g[2:0], s[4:0]};
            end
         end
      end
      return ans;
   endfunction

   // Random id among the level's live slots; found is low when the level is empty.
   function automatic logic [15:0] pick_live_id(input logic [1:0] lvl, output bit found);
      int          first, last;
      logic [15:0] pool[$];
      level_groups(lvl, first, last);
      for (int g = first; g < last; g++)
         for (int s = 0; s < SLOTS; s++)
            if (occ_bits[g][s]) pool.push_back(held_id[g*SLOTS + s]);
      found = (pool.size() != 0);
      return found ? pool[$urandom_range(0, pool.size() - 1)] : 16'd0;
   endfunction

   function automatic void note_fault(input string what, input slot_answer_type want,
                                      input slot_answer_type got);
      fault_count++;
      if (fault_count <= 10)
         $display("%0t: %s: expected st=%0d grp=%0d slot=%0d, got st=%0d grp=%0d slot=%0d",
                  $realtime, what, want.status, want.grp, want.slot,
                  got.status, got.grp, got.slot);
   endfunction

   // Monitor: everything sampled at the edge, before any NBA of that step lands.
   // A result is checked before a word taken at the same edge is booked.
   always @(posedge clock) begin
      slot_answer_type got, want, pred;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_status, rsp_group_index, rsp_slot_index};
            if (answers_due.size() == 0) begin
               note_fault("result word with nothing pending", '0, got);
            end else begin
               want = answers_due.pop_front();
               if (got.status != want.status || got.grp != want.grp ||
                   got.slot != want.slot)
                  note_fault("result word mismatch", want, got);
            end
         end
         if (start && !busy) begin
            pred = book_slot_op(req_action, req_level, req_task_id, req_period,
                                req_start_tick);
            answers_due.push_back(typed_known ? typed_answer : pred);
         end
      end
   end

   // Present one word and hold it until taken.
   task automatic put_word(input logic act, input logic [1:0] lvl, input logic [15:0] id,
                           input logic [15:0] per, input logic [15:0] st, input bit known,
                           input slot_answer_type ans);
      req_action     <= act;
      req_level      <= lvl;
      req_task_id    <= id;
      req_period     <= per;
      req_start_tick <= st;
      typed_known    <= known;
      typed_answer   <= ans;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic sit_idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender pause until every pending answer is back.
   task automatic hold_until_drained();
      start <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   stim_row_type directed_rows [N_ROWS] = '{
      // empty table: delete misses
      '{ACTION_DEL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1, 1, '{STATUS_NOT_FOUND, 3'd0, 5'd0}},
      // all-ones fields, then a duplicate id in the same level
      '{ACTION_ADD, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, '{STATUS_DONE, 3'd0, 5'd0}},
      '{ACTION_ADD, 2'd3, 16'hFFFF, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd0, 5'd1}},
      '{ACTION_ADD, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd6, 5'd0}},
      '{ACTION_ADD, 2'd1, 16'h1234, 16'h8000, 16'h0001, 1, 1, '{STATUS_DONE, 3'd4, 5'd0}},
      '{ACTION_ADD, 2'd2, 16'h1234, 16'h7FFF, 16'hFFFE, 1, 1, '{STATUS_DONE, 3'd2, 5'd0}},
      // duplicates go in scan order, then miss
      '{ACTION_DEL, 2'd3, 16'hFFFF, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd0, 5'd0}},
      '{ACTION_DEL, 2'd3, 16'hFFFF, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd0, 5'd1}},
      '{ACTION_DEL, 2'd3, 16'hFFFF, 16'h0000, 16'h0000, 1, 1, '{STATUS_NOT_FOUND, 3'd0, 5'd0}},
      // occupied slot with a different id
      '{ACTION_DEL, 2'd1, 16'h5555, 16'hAAAA, 16'h5555, 1, 1, '{STATUS_NOT_FOUND, 3'd0, 5'd0}},
      // same id in another level is untouched
      '{ACTION_DEL, 2'd1, 16'h1234, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd4, 5'd0}},
      '{ACTION_DEL, 2'd2, 16'h1234, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd2, 5'd0}},
      // fill level 2 right across its group boundary
      '{ACTION_ADD, 2'd2, 16'h0100, 16'hA5A5, 16'h5A5A, 64, 0, '{STATUS_DONE, 3'd0, 5'd0}},
      '{ACTION_ADD, 2'd2, 16'hBEEF, 16'h0000, 16'h0000, 1, 1, '{STATUS_FULL, 3'd0, 5'd0}},
      // last slot of the walk, then first
      '{ACTION_DEL, 2'd2, 16'h013F, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd3, 5'd31}},
      '{ACTION_DEL, 2'd2, 16'h0100, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd2, 5'd0}},
      '{ACTION_ADD, 2'd2, 16'h0ABC, 16'h1111, 16'h2222, 1, 1, '{STATUS_DONE, 3'd2, 5'd0}},
      '{ACTION_ADD, 2'd2, 16'h0ABD, 16'h3333, 16'h4444, 1, 1, '{STATUS_DONE, 3'd3, 5'd31}},
      '{ACTION_ADD, 2'd2, 16'h0ABE, 16'h0000, 16'h0000, 1, 1, '{STATUS_FULL, 3'd0, 5'd0}},
      '{ACTION_DEL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1, 1, '{STATUS_DONE, 3'd6, 5'd0}},
      '{ACTION_DEL, 2'd0, 16'h0000, 16'h0000, 16'h0000, 1, 1, '{STATUS_NOT_FOUND, 3'd0, 5'd0}}
   };

   // Random phases: sender idle percentage, add share, each with a hot level.
   int idle_pct [4] = '{0, 76, 0, 35};
   int add_pct  [4] = '{70, 50, 80, 35};

   initial begin
      logic [1:0]  lvl, hot;
      logic        act;
      logic [15:0] id;
      bit          found;

      for (int g = 0; g < ALL_GROUPS; g++) occ_bits[g] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++)
            put_word(directed_rows[r].act, directed_rows[r].lvl,
                     directed_rows[r].id + k[15:0], directed_rows[r].per,
                     directed_rows[r].st, directed_rows[r].known, directed_rows[r].ans);
      end
      hold_until_drained();

      // Random phases; mostly live-id deletes so the delete walk hits deep slots
      for (int ph = 0; ph < 4; ph++) begin
         hot = 2'($urandom_range(0, 3));
         for (int n = 0; n < RAND_WORDS; n++) begin
            lvl = ($urandom_range(0, 1) == 0) ? hot : 2'($urandom_range(0, 3));
            act = ($urandom_range(0, 99) < add_pct[ph]) ? ACTION_ADD : ACTION_DEL;
            if (act == ACTION_ADD) begin
               id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                                : 16'($urandom);
            end else begin
               id = pick_live_id(lvl, found);
               if (!found || $urandom_range(0, 4) == 0) id = 16'($urandom);
            end
            put_word(act, lvl, id, 16'($urandom), 16'($urandom), 1'b0, '0);
            if ($urandom_range(0, 99) < idle_pct[ph])
               sit_idle($urandom_range(1, 8));
         end
         hold_until_drained();
      end

      repeat (TAIL_WAIT) @(posedge clock);
      if (fault_count == 0 && answers_due.size() == 0)
         $display("** leveled_task_slot_table: PASSED **");
      else
         $display("** leveled_task_slot_table: FAILED **");
      $finish;
   end

endmodule
